### rtl/core/plt_pkg.sv
// plt_pkg: shared types and constants for the piecewise linear table lookup core
// no dependencies

package plt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               valid;
        logic               done;
        logic               lerp;
        logic signed [31:0] q;
        logic signed [31:0] xa;
        logic signed [31:0] ya;
        logic signed [31:0] xb;
        logic signed [31:0] yb;
        logic signed [31:0] res;
    } plt_tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } plt_state_t;

    typedef enum logic [1:0] {
        IP_IDLE,
        IP_MUL,
        IP_DIV,
        IP_SAT
    } plt_phase_t;

endpackage

### rtl/core/plt_cell.sv
// plt_cell: one breakpoint of the table and one step of the query scan
// depends on plt_pkg

module plt_cell
    import plt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   pos,
    input  logic [CNT_W-1:0]   n,
    input  logic               wr_en,
    input  logic signed [31:0] wr_x,
    input  logic signed [31:0] wr_y,
    input  plt_tok_t           tok_in,
    output plt_tok_t           tok_out
);

    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    plt_tok_t           tok_reg;
    plt_tok_t           tok_next;
    logic               active;

    assign active = (pos < n);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_reg <= wr_x;
            y_reg <= wr_y;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.done && active)
        begin
            if (pos == '0)
            begin
                tok_next.res  = y_reg;
                tok_next.xa   = x_reg;
                tok_next.ya   = y_reg;
                tok_next.done = !((n > CNT_W'(1)) && (x_reg < tok_in.q));
            end
            else if (x_reg == tok_in.q)
            begin
                tok_next.res  = y_reg;
                tok_next.done = 1'b1;
            end
            else if ((x_reg > tok_in.q) && (tok_in.xa < tok_in.q))
            begin
                tok_next.lerp = 1'b1;
                tok_next.done = 1'b1;
                tok_next.xb   = x_reg;
                tok_next.yb   = y_reg;
            end
            else
            begin
                tok_next.xa  = x_reg;
                tok_next.ya  = y_reg;
                tok_next.res = y_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

### rtl/core/plt_interp.sv
// plt_interp: multiply then serial divide for the interpolation, with saturation
// depends on plt_pkg

module plt_interp
    import plt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] xa,
    input  logic signed [31:0] ya,
    input  logic signed [31:0] xb,
    input  logic signed [31:0] yb,
    input  logic signed [31:0] q,
    output logic               done,
    output logic signed [31:0] result
);

    plt_phase_t         phase_reg;
    plt_phase_t         phase_next;
    logic [4:0]         cnt_reg;
    logic [31:0]        mag_reg;
    logic [31:0]        dq_reg;
    logic [31:0]        dx_reg;
    logic               neg_reg;
    logic signed [31:0] ya_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        quo_reg;
    logic               done_reg;
    logic signed [31:0] res_reg;

    logic signed [32:0] dy;
    logic signed [32:0] dy_abs;
    logic signed [32:0] dq_w;
    logic signed [32:0] dx_w;
    logic [63:0]        prod;
    logic [32:0]        trial;
    logic               fits;
    logic signed [33:0] sum;

    assign dy     = 33'(yb) - 33'(ya);
    assign dy_abs = dy[32] ? -dy : dy;
    assign dq_w   = 33'(q) - 33'(xa);
    assign dx_w   = 33'(xb) - 33'(xa);
    assign prod   = 64'(mag_reg) * 64'(dq_reg);
    assign trial  = {rem_reg, quo_reg[31]};
    assign fits   = (trial >= {1'b0, dx_reg});
    assign sum    = neg_reg ? (34'(ya_reg) - $signed({2'b00, quo_reg}))
                            : (34'(ya_reg) + $signed({2'b00, quo_reg}));

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            IP_IDLE: if (start) phase_next = IP_MUL;
            IP_MUL:  phase_next = IP_DIV;
            IP_DIV:  if (cnt_reg == 5'd31) phase_next = IP_SAT;
            IP_SAT:  phase_next = IP_IDLE;
            default: phase_next = IP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= IP_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == IP_SAT);
            if (phase_reg == IP_DIV)
                cnt_reg <= cnt_reg + 5'd1;
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            IP_IDLE:
            begin
                if (start)
                begin
                    mag_reg <= dy_abs[31:0];
                    neg_reg <= dy[32];
                    dq_reg  <= dq_w[31:0];
                    dx_reg  <= dx_w[31:0];
                    ya_reg  <= ya;
                end
            end
            IP_MUL:
            begin
                rem_reg <= prod[63:32];
                quo_reg <= prod[31:0];
            end
            IP_DIV:
            begin
                rem_reg <= fits ? 32'(trial - {1'b0, dx_reg}) : trial[31:0];
                quo_reg <= {quo_reg[30:0], fits};
            end
            IP_SAT:
            begin
                if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111)
                    res_reg <= sum[31:0];
                else if (sum[33])
                    res_reg <= 32'sh8000_0000;
                else
                    res_reg <= 32'sh7fff_ffff;
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### rtl/core/piecewise_linear_table_lookup_core.sv
// piecewise_linear_table_lookup_core: top level, cell chain, sequencer and output register
// depends on plt_pkg, plt_cell, plt_interp

// Breakpoints live in a chain of TABLE_DEPTH cells, one (x, y) pair each; a load item
// writes one cell and yields no result. A query item walks the chain one cell per
// cycle, and when it lands between two breakpoints it goes through a 32x32 multiply
// and a one-bit-per-cycle 32-step divider plus a saturation step. The result of a
// query is offered once its token leaves the chain when no interpolation is needed,
// and after the multiply, divide and saturation steps when it is; an empty table
// offers it on the next cycle. The next item is taken in the cycle after the result
// leaves. One query is worked on at a time; in_stall is high while it is in flight.

module piecewise_linear_table_lookup_core
    import plt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [3:0]         point_index,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] query_x,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_y,
    output logic               empty_table
);

    plt_state_t         state_reg;
    plt_state_t         state_next;
    logic [4:0]         points_reg;
    logic [CNT_W-1:0]   n;
    logic signed [31:0] res_reg;
    logic               empty_reg;
    logic               in_acc;
    logic               q_acc;
    logic               ld_acc;
    plt_tok_t           tok_chain [0:TABLE_DEPTH];
    plt_tok_t           last;
    logic               ip_start;
    logic               ip_done;
    logic signed [31:0] ip_result;

    assign n = (32'(points_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(points_reg);

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign q_acc    = in_acc && (operation == OP_QUERY);
    assign ld_acc   = in_acc && (operation == OP_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            points_reg <= '0;
        else if (cfg_we)
            points_reg <= cfg_data;
    end

    // entry token for the first cell
    always_comb
    begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = q_acc && (n != '0);
        tok_chain[0].q     = query_x;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        plt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .pos     (CNT_W'(i)),
            .n       (n),
            .wr_en   (ld_acc && (32'(point_index) == i)),
            .wr_x    (point_x),
            .wr_y    (point_y),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1])
        );
    end

    assign last     = tok_chain[TABLE_DEPTH];
    assign ip_start = (state_reg == ST_SCAN) && last.valid && last.lerp;

    plt_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ip_start),
        .xa     (last.xa),
        .ya     (last.ya),
        .xb     (last.xb),
        .yb     (last.yb),
        .q      (last.q),
        .done   (ip_done),
        .result (ip_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_acc)
                    state_next = (n == '0) ? ST_OUT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (last.valid)
                    state_next = last.lerp ? ST_DIV : ST_OUT;
            end
            ST_DIV:
            begin
                if (ip_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_acc && (n == '0))
        begin
            res_reg   <= '0;
            empty_reg <= 1'b1;
        end
        else if ((state_reg == ST_SCAN) && last.valid && !last.lerp)
        begin
            res_reg   <= last.res;
            empty_reg <= 1'b0;
        end
        else if ((state_reg == ST_DIV) && ip_done)
        begin
            res_reg   <= ip_result;
            empty_reg <= 1'b0;
        end
    end

    always_comb
    begin
        out_valid   = (state_reg == ST_OUT);
        result_y    = res_reg;
        empty_table = empty_reg;
    end

    a_chain_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        last.valid |-> (state_reg == ST_SCAN))
        else $error("scan token left the chain outside the scan state");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        ip_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_table) |-> (result_y == '0))
        else $error("empty table item carries a nonzero result");

    a_scan_follows_query: assert property (@(posedge clk) disable iff (!rst_n)
        (q_acc && (n != '0)) |=> (state_reg == ST_SCAN))
        else $error("query did not start a scan");

endmodule
